>>> hdl/sbsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbsr_pkg
// Shared widths, register codes, pipeline payload types and the divider step
// for the sprite blitter.
// ----------------------------------------------------------------------------
package sbsr_pkg;

    localparam int COL_W       = 8;
    localparam int PIX_W       = 32;
    localparam int IN_W        = 2 * COL_W + PIX_W;
    localparam int ORIGIN_W    = 12;
    localparam int STRIDE_W    = 13;
    localparam int RATIO_W     = 9;
    localparam int SIZE_W      = 9;
    localparam int COORD_W     = SIZE_W;
    localparam int POS_W       = ORIGIN_W + 1;
    localparam int PROD_W      = POS_W + STRIDE_W;
    localparam int ADDR_FULL_W = PROD_W + 1;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;

    localparam int DIV_STAGES          = 3;
    localparam int DIV_STEPS_PER_STAGE = COORD_W / DIV_STAGES;

    localparam int MAX_SPRITE_DEF   = 256;
    localparam int FB_ADDR_BITS_DEF = 24;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(1024);
    localparam logic [RATIO_W-1:0]  RATIO_RESET  = RATIO_W'(1);
    localparam logic [SIZE_W-1:0]   SIZE_RESET   = SIZE_W'(64);

    typedef enum logic [1:0] {
        ORIENT_NONE             = 2'd0,
        ORIENT_TRANSPOSE        = 2'd1,
        ORIENT_TRANSPOSE_MIRROR = 2'd2,
        ORIENT_HMIRROR          = 2'd3
    } orient_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X    = 3'd0,
        REG_ORIGIN_Y    = 3'd1,
        REG_LINE_STRIDE = 3'd2,
        REG_SCALE_RATIO = 3'd3,
        REG_SPRITE_SIZE = 3'd4,
        REG_ORIENTATION = 3'd5,
        REG_COLOR_KEY   = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [ORIGIN_W-1:0] origin_x;
        logic [ORIGIN_W-1:0] origin_y;
        logic [STRIDE_W-1:0] line_stride_words;
        logic [RATIO_W-1:0]  scale_ratio;
        logic [SIZE_W-1:0]   sprite_size;
        orient_t             orientation_mode;
        logic                color_key_enable;
    } sbsr_cfg_t;

    // One lane of the restoring divider: partial remainder and the dividend
    // shifting out at the top while quotient bits shift in at the bottom.
    typedef struct packed {
        logic [COORD_W-1:0] rem;
        logic [COORD_W-1:0] num;
    } sbsr_lane_t;

    typedef struct packed {
        sbsr_lane_t        row;
        sbsr_lane_t        col;
        logic [PIX_W-1:0]  px;
    } sbsr_div_t;

    function automatic sbsr_lane_t div_step(sbsr_lane_t lane, logic [RATIO_W-1:0] ratio);
        logic [COORD_W:0] trial;
        sbsr_lane_t       res;
        trial = {lane.rem, lane.num[COORD_W-1]};
        if (trial >= {1'b0, ratio})
        begin
            res.rem = COORD_W'(trial - {1'b0, ratio});
            res.num = {lane.num[COORD_W-2:0], 1'b1};
        end
        else
        begin
            res.rem = trial[COORD_W-1:0];
            res.num = {lane.num[COORD_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

>>> hdl/sbsr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbsr_front
// Input stage: sprite bounds check, color key and orientation remap.
// ----------------------------------------------------------------------------
module sbsr_front #(
    parameter int MAX_SPRITE = sbsr_pkg::MAX_SPRITE_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  sbsr_pkg::sbsr_cfg_t           cfg,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire [sbsr_pkg::COL_W-1:0]     in_col,
    input  wire [sbsr_pkg::COL_W-1:0]     in_row,
    input  wire [sbsr_pkg::PIX_W-1:0]     in_px,
    output logic                          out_valid,
    input  wire                           out_ready,
    output sbsr_pkg::sbsr_div_t           out_data
);
    import sbsr_pkg::*;

    logic [SIZE_W-1:0]  size_eff;
    logic [COORD_W-1:0] col_ext;
    logic [COORD_W-1:0] row_ext;
    logic [COORD_W-1:0] col_mir;
    logic [COORD_W-1:0] row_mir;
    logic               in_sprite;
    logic               keyed_out;
    logic               keep;
    logic [COORD_W-1:0] drow;
    logic [COORD_W-1:0] dcol;
    logic               valid_reg;
    sbsr_div_t          data_reg;
    sbsr_div_t          data_next;

    assign size_eff = (32'(cfg.sprite_size) > MAX_SPRITE) ? SIZE_W'(MAX_SPRITE)
                                                         : cfg.sprite_size;
    assign col_ext  = COORD_W'(in_col);
    assign row_ext  = COORD_W'(in_row);
    assign col_mir  = size_eff - COORD_W'(1) - col_ext;
    assign row_mir  = size_eff - COORD_W'(1) - row_ext;

    assign in_sprite = (col_ext < size_eff) && (row_ext < size_eff);
    assign keyed_out = cfg.color_key_enable && ((in_px == '0) || in_px[PIX_W-1]);
    assign keep      = in_sprite && !keyed_out;

    always_comb
    begin
        unique case (cfg.orientation_mode)
            ORIENT_TRANSPOSE:
            begin
                drow = col_ext;
                dcol = row_ext;
            end
            ORIENT_TRANSPOSE_MIRROR:
            begin
                drow = col_mir;
                dcol = row_mir;
            end
            ORIENT_HMIRROR:
            begin
                drow = row_ext;
                dcol = col_mir;
            end
            default:
            begin
                drow = row_ext;
                dcol = col_ext;
            end
        endcase
    end

    always_comb
    begin
        data_next.row.rem = '0;
        data_next.row.num = drow;
        data_next.col.rem = '0;
        data_next.col.num = dcol;
        data_next.px      = in_px;
    end

    assign in_ready = !valid_reg || out_ready;

    // Drop skipped pixels here: they leave a bubble, not a beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid && keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

>>> hdl/sbsr_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbsr_div_stage
// One registered slice of the row and column restoring dividers.
// ----------------------------------------------------------------------------
module sbsr_div_stage #(
    parameter int STEPS = sbsr_pkg::DIV_STEPS_PER_STAGE
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire [sbsr_pkg::RATIO_W-1:0]    ratio,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  sbsr_pkg::sbsr_div_t            in_data,
    output logic                           out_valid,
    input  wire                            out_ready,
    output sbsr_pkg::sbsr_div_t            out_data
);
    import sbsr_pkg::*;

    sbsr_div_t data_next;
    sbsr_div_t data_reg;
    logic      valid_reg;

    always_comb
    begin
        data_next = in_data;
        for (int i = 0; i < STEPS; i++)
        begin
            data_next.row = div_step(data_next.row, ratio);
            data_next.col = div_step(data_next.col, ratio);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

>>> hdl/sbsr_addr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbsr_addr
// Address back end: origin offset, row times stride, column add, range
// check and the output register.
// ----------------------------------------------------------------------------
module sbsr_addr #(
    parameter int FB_ADDR_BITS = sbsr_pkg::FB_ADDR_BITS_DEF
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  sbsr_pkg::sbsr_cfg_t         cfg,
    input  wire                         in_valid,
    output logic                        in_ready,
    input  sbsr_pkg::sbsr_div_t         in_data,
    output logic                        out_valid,
    input  wire                         out_ready,
    output logic [FB_ADDR_BITS-1:0]     out_addr,
    output logic [sbsr_pkg::PIX_W-1:0]  out_px
);
    import sbsr_pkg::*;

    // stage 1: origin offset
    logic                   v1_reg;
    logic [POS_W-1:0]       row1_reg;
    logic [POS_W-1:0]       col1_reg;
    logic [PIX_W-1:0]       px1_reg;
    logic [POS_W-1:0]       row1_next;
    logic [POS_W-1:0]       col1_next;
    // stage 2: row times stride
    logic                   v2_reg;
    logic [PROD_W-1:0]      prod2_reg;
    logic [POS_W-1:0]       col2_reg;
    logic [PIX_W-1:0]       px2_reg;
    logic [PROD_W-1:0]      prod2_next;
    // stage 3: column add and range check
    logic                   v3_reg;
    logic [FB_ADDR_BITS-1:0] addr3_reg;
    logic [PIX_W-1:0]       px3_reg;
    logic [ADDR_FULL_W-1:0] addr_full;
    logic [63:0]            addr_wide;
    logic                   in_range;

    logic r1;
    logic r2;
    logic r3;

    assign r3       = !v3_reg || out_ready;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    // the dividend lanes now hold the quotients
    assign row1_next  = POS_W'(cfg.origin_y) + POS_W'(in_data.row.num);
    assign col1_next  = POS_W'(cfg.origin_x) + POS_W'(in_data.col.num);
    assign prod2_next = PROD_W'(row1_reg) * PROD_W'(cfg.line_stride_words);
    assign addr_full  = ADDR_FULL_W'(prod2_reg) + ADDR_FULL_W'(col2_reg);
    assign addr_wide  = 64'(addr_full);
    assign in_range   = (addr_wide >> FB_ADDR_BITS) == 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                v1_reg <= in_valid;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
            // drop writes past the frame store
            if (r3)
            begin
                v3_reg <= v2_reg && in_range;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && in_valid)
        begin
            row1_reg <= row1_next;
            col1_reg <= col1_next;
            px1_reg  <= in_data.px;
        end
        if (r2 && v1_reg)
        begin
            prod2_reg <= prod2_next;
            col2_reg  <= col1_reg;
            px2_reg   <= px1_reg;
        end
        if (r3 && v2_reg)
        begin
            addr3_reg <= FB_ADDR_BITS'(addr_full);
            px3_reg   <= px2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_addr  = addr3_reg;
    assign out_px    = px3_reg;

endmodule
`default_nettype wire

>>> hdl/sprite_blit_scale_rotate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_blit_scale_rotate
// Sprite blitter: orientation remap, integer downscale, placement and color
// key, one source pixel in, at most one frame store write out.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  s_axis    in   src_col, src_row, pixel_value
//  m_axis    out  write_address, write_value
//  cfg       in   register index, write data (always ready)
//
//  One beat per cycle in and out while m_axis is ready; the stages are the front
//  stage, three divider stages of three quotient bits each, offset, multiply, address add.
//  Skipped pixels and writes past the frame store produce no output beat.
//  Reset clears the valid bits and loads the register defaults.
//  Backpressure on m_axis fills empty stages first; s_axis stalls only when
//  every stage holds a beat.
// ----------------------------------------------------------------------------
module sprite_blit_scale_rotate #(
    parameter int MAX_SPRITE   = sbsr_pkg::MAX_SPRITE_DEF,
    parameter int FB_ADDR_BITS = sbsr_pkg::FB_ADDR_BITS_DEF,
    localparam int OUT_W       = ((FB_ADDR_BITS + sbsr_pkg::PIX_W + 7) / 8) * 8
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] src_col, [15:8] src_row, [47:16] pixel_value
    input  wire [sbsr_pkg::IN_W-1:0]          s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // [FB_ADDR_BITS-1:0] write_address, next 32 bits write_value, zero pad
    output logic [OUT_W-1:0]                  m_axis_tdata,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire [sbsr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [sbsr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sbsr_pkg::*;

    logic [ORIGIN_W-1:0] origin_x_reg;
    logic [ORIGIN_W-1:0] origin_y_reg;
    logic [STRIDE_W-1:0] line_stride_reg;
    logic [RATIO_W-1:0]  scale_ratio_reg;
    logic [SIZE_W-1:0]   sprite_size_reg;
    orient_t             orientation_reg;
    logic                color_key_reg;
    sbsr_cfg_t           cfg;

    logic                div_valid [DIV_STAGES+1];
    logic                div_ready [DIV_STAGES+1];
    sbsr_div_t           div_data  [DIV_STAGES+1];

    logic [FB_ADDR_BITS-1:0] out_addr;
    logic [PIX_W-1:0]        out_px;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            line_stride_reg <= STRIDE_RESET;
            scale_ratio_reg <= RATIO_RESET;
            sprite_size_reg <= SIZE_RESET;
            orientation_reg <= ORIENT_NONE;
            color_key_reg   <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ORIGIN_X:    origin_x_reg    <= cfg_data[ORIGIN_W-1:0];
                REG_ORIGIN_Y:    origin_y_reg    <= cfg_data[ORIGIN_W-1:0];
                REG_LINE_STRIDE: line_stride_reg <= cfg_data[STRIDE_W-1:0];
                // a zero ratio divides by one
                REG_SCALE_RATIO: scale_ratio_reg <= (cfg_data[RATIO_W-1:0] == '0)
                                                    ? RATIO_RESET
                                                    : cfg_data[RATIO_W-1:0];
                REG_SPRITE_SIZE: sprite_size_reg <= cfg_data[SIZE_W-1:0];
                REG_ORIENTATION: orientation_reg <= orient_t'(cfg_data[1:0]);
                REG_COLOR_KEY:   color_key_reg   <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        cfg.origin_x          = origin_x_reg;
        cfg.origin_y          = origin_y_reg;
        cfg.line_stride_words = line_stride_reg;
        cfg.scale_ratio       = scale_ratio_reg;
        cfg.sprite_size       = sprite_size_reg;
        cfg.orientation_mode  = orientation_reg;
        cfg.color_key_enable  = color_key_reg;
    end

    sbsr_front #(
        .MAX_SPRITE (MAX_SPRITE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_col    (s_axis_tdata[COL_W-1:0]),
        .in_row    (s_axis_tdata[2*COL_W-1:COL_W]),
        .in_px     (s_axis_tdata[IN_W-1:2*COL_W]),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_data  (div_data[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        sbsr_div_stage #(
            .STEPS (DIV_STEPS_PER_STAGE)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .ratio     (scale_ratio_reg),
            .in_valid  (div_valid[g]),
            .in_ready  (div_ready[g]),
            .in_data   (div_data[g]),
            .out_valid (div_valid[g+1]),
            .out_ready (div_ready[g+1]),
            .out_data  (div_data[g+1])
        );
    end

    sbsr_addr #(
        .FB_ADDR_BITS (FB_ADDR_BITS)
    ) u_addr (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (div_valid[DIV_STAGES]),
        .in_ready  (div_ready[DIV_STAGES]),
        .in_data   (div_data[DIV_STAGES]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_addr  (out_addr),
        .out_px    (out_px)
    );

    assign m_axis_tdata = OUT_W'({out_px, out_addr});

`ifndef NO_ASSERTIONS
    // the divider must never see a zero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        scale_ratio_reg != '0)
        else $error("scale ratio register holds zero");

    // input stalls only when the whole pipeline is full behind a blocked output
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while output not backpressured");

    // hold a stalled output beat steady until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output beat changed while stalled");
`endif

endmodule
`default_nettype wire

>>> dv/sprite_blit_scale_rotate_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_blit_scale_rotate_tb
// Streams source sprite pixels through the blitter under a sequence of
// register settings and checks every frame store write against a predicted
// write. Both stream sides idle at random, and the output is held off once
// long enough to back the pipeline up into the input.
// ----------------------------------------------------------------------------
module sprite_blit_scale_rotate_tb;
    import sbsr_pkg::*;

    localparam int     OUT_W         = 56;
    localparam int     ADDR_W        = FB_ADDR_BITS_DEF;
    localparam int     SPRITE_MAX    = MAX_SPRITE_DEF;
    localparam int     RANDOM_ITEMS  = 1900;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     SETTLE_CYCLES = 20;
    localparam longint CYCLE_LIMIT   = 600000;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [PIX_W-1:0]  value;
    } fb_write_t;

    // Predicts frame store writes from accepted pixels and checks the block's.
    class blit_scoreboard;
        sbsr_cfg_t regs;
        fb_write_t expected_writes[$];
        int        errors;

        function new();
            regs.origin_x          = '0;
            regs.origin_y          = '0;
            regs.line_stride_words = STRIDE_RESET;
            regs.scale_ratio       = RATIO_RESET;
            regs.sprite_size       = SIZE_RESET;
            regs.orientation_mode  = ORIENT_NONE;
            regs.color_key_enable  = 1'b1;
            errors = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ORIGIN_X:    regs.origin_x = data[ORIGIN_W-1:0];
                REG_ORIGIN_Y:    regs.origin_y = data[ORIGIN_W-1:0];
                REG_LINE_STRIDE: regs.line_stride_words = data[STRIDE_W-1:0];
                REG_SCALE_RATIO: regs.scale_ratio = data[RATIO_W-1:0];
                REG_SPRITE_SIZE: regs.sprite_size = data[SIZE_W-1:0];
                REG_ORIENTATION: regs.orientation_mode = orient_t'(data[1:0]);
                REG_COLOR_KEY:   regs.color_key_enable = data[0];
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [COL_W-1:0] col, logic [COL_W-1:0] row,
                                 logic [PIX_W-1:0] px);
            longint unsigned side;
            longint unsigned ratio;
            longint unsigned drow;
            longint unsigned dcol;
            longint unsigned addr;
            fb_write_t       w;
            side = 64'(regs.sprite_size);
            if (side > 64'(SPRITE_MAX))
                side = 64'(SPRITE_MAX);
            ratio = (regs.scale_ratio == '0) ? 64'd1 : 64'(regs.scale_ratio);
            if (64'(col) >= side || 64'(row) >= side)
                return;
            // color key: only positive 32-bit words pass
            if (regs.color_key_enable && (px == '0 || px[PIX_W-1]))
                return;
            case (regs.orientation_mode)
                ORIENT_TRANSPOSE:
                begin
                    drow = 64'(col);
                    dcol = 64'(row);
                end
                ORIENT_TRANSPOSE_MIRROR:
                begin
                    drow = side - 64'd1 - 64'(col);
                    dcol = side - 64'd1 - 64'(row);
                end
                ORIENT_HMIRROR:
                begin
                    drow = 64'(row);
                    dcol = side - 64'd1 - 64'(col);
                end
                default:
                begin
                    drow = 64'(row);
                    dcol = 64'(col);
                end
            endcase
            drow = 64'(regs.origin_y) + drow / ratio;
            dcol = 64'(regs.origin_x) + dcol / ratio;
            addr = drow * 64'(regs.line_stride_words) + dcol;
            if (addr >= (64'd1 << ADDR_W))
                return;
            w.address = addr[ADDR_W-1:0];
            w.value   = px;
            expected_writes.push_back(w);
        endfunction

        function void check_write(fb_write_t got);
            fb_write_t want;
            if (expected_writes.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected write address=%h value=%h",
                             got.address, got.value);
                return;
            end
            want = expected_writes.pop_front();
            if (got.address !== want.address || got.value !== want.value)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: expected address=%h value=%h, got address=%h value=%h",
                             want.address, want.value, got.address, got.value);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [7:0] src_col, [15:8] src_row, [47:16] pixel_value
    logic [IN_W-1:0]       s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [23:0] write_address, [55:24] write_value
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    blit_scoreboard board = new();
    bit             tx_idle_on = 1'b1;
    bit             hold_request = 1'b0;
    longint         cycle_count = 0;
    int             random_sent = 0;

    sprite_blit_scale_rotate DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever
            #4 clk = ~clk;
    end

    task automatic send_pixel(input logic [COL_W-1:0] col, input logic [COL_W-1:0] row,
                              input logic [PIX_W-1:0] px);
        int gap;
        gap = tx_idle_on ? int'($urandom_range(0, 18)) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {px, row, col};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_pixel(col, row, px);
    endtask

    // Drop the input and wait out every pending write, plus the pipeline depth
    // for pixels that make no write.
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (board.expected_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_reg(idx, data);
    endtask

    task automatic apply_config(input sbsr_cfg_t c);
        drain_block();
        write_reg(REG_ORIGIN_X, CFG_DATA_W'(c.origin_x));
        write_reg(REG_ORIGIN_Y, CFG_DATA_W'(c.origin_y));
        write_reg(REG_LINE_STRIDE, CFG_DATA_W'(c.line_stride_words));
        write_reg(REG_SCALE_RATIO, CFG_DATA_W'(c.scale_ratio));
        write_reg(REG_SPRITE_SIZE, CFG_DATA_W'(c.sprite_size));
        write_reg(REG_ORIENTATION, CFG_DATA_W'(c.orientation_mode));
        write_reg(REG_COLOR_KEY, CFG_DATA_W'(c.color_key_enable));
        cfg_valid <= 1'b0;
    endtask

    function automatic sbsr_cfg_t make_config(int ox, int oy, int stride, int ratio, int size,
                                              orient_t mode, bit key);
        sbsr_cfg_t c;
        c.origin_x          = ORIGIN_W'(ox);
        c.origin_y          = ORIGIN_W'(oy);
        c.line_stride_words = STRIDE_W'(stride);
        c.scale_ratio       = RATIO_W'(ratio);
        c.sprite_size       = SIZE_W'(size);
        c.orientation_mode  = mode;
        c.color_key_enable  = key;
        return c;
    endfunction

    function automatic sbsr_cfg_t random_config();
        sbsr_cfg_t c;
        c.origin_x = ORIGIN_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                           : $urandom_range(0, 255));
        c.origin_y = ORIGIN_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                           : $urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0: c.line_stride_words = '0;
            1: c.line_stride_words = STRIDE_W'(1);
            2: c.line_stride_words = STRIDE_W'(4096);
            3: c.line_stride_words = STRIDE_W'($urandom_range(4097, 8191));
            default: c.line_stride_words = STRIDE_W'($urandom_range(1, 2048));
        endcase
        case ($urandom_range(0, 7))
            0: c.scale_ratio = '0;
            1: c.scale_ratio = RATIO_W'(256);
            2: c.scale_ratio = RATIO_W'($urandom_range(257, 511));
            3: c.scale_ratio = RATIO_W'($urandom_range(1, 256));
            default: c.scale_ratio = RATIO_W'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 9))
            0: c.sprite_size = '0;
            1: c.sprite_size = SIZE_W'(1);
            2: c.sprite_size = SIZE_W'(256);
            3: c.sprite_size = SIZE_W'($urandom_range(257, 511));
            default: c.sprite_size = SIZE_W'($urandom_range(2, 256));
        endcase
        c.orientation_mode = orient_t'($urandom_range(0, 3));
        c.color_key_enable = 1'($urandom_range(0, 1));
        return c;
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return {1'b1, 31'($urandom)};
            2: return 32'hFFFF_FFFF;
            3: return 32'h7FFF_FFFF;
            4: return $urandom;
            default: return {1'b0, 31'($urandom)};
        endcase
    endfunction

    // Receiver: check each output beat, then draw the stall before the next.
    initial
    begin : receiver
        int stall;
        bit idle_on;
        fb_write_t got;
        stall = 0;
        idle_on = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.address = m_axis_tdata[ADDR_W-1:0];
                got.value   = m_axis_tdata[ADDR_W+PIX_W-1:ADDR_W];
                board.check_write(got);
                if ($urandom_range(0, 39) == 0)
                    idle_on = !idle_on;
                stall = idle_on ? int'($urandom_range(0, 18)) : 0;
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end
            m_axis_tready <= (stall == 0);
            if (stall > 0)
                stall--;
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        sbsr_cfg_t c;
        int phase;
        int phase_len;
        int side;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] row;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 64 pixel sprite, key on
        send_pixel(8'd0, 8'd0, 32'h0000_0001);
        send_pixel(8'd63, 8'd63, 32'h7FFF_FFFF);
        send_pixel(8'd64, 8'd0, 32'h0000_0005);
        send_pixel(8'd0, 8'd64, 32'h0000_0005);
        send_pixel(8'd255, 8'd255, 32'hFFFF_FFFF);
        send_pixel(8'd1, 8'd2, 32'h0000_0000);
        send_pixel(8'd3, 8'd4, 32'h8000_0000);

        apply_config(make_config(100, 200, 640, 3, 16, ORIENT_TRANSPOSE, 1'b0));
        send_pixel(8'd0, 8'd15, 32'h0000_0000);
        send_pixel(8'd15, 8'd0, 32'hFFFF_FFFF);
        send_pixel(8'd5, 8'd9, 32'h1234_5678);

        apply_config(make_config(100, 200, 640, 3, 16, ORIENT_TRANSPOSE_MIRROR, 1'b0));
        send_pixel(8'd0, 8'd0, 32'h0000_0001);
        send_pixel(8'd15, 8'd15, 32'h0000_0002);

        // zero ratio, oversize sprite, zero stride
        apply_config(make_config(4095, 4095, 0, 0, 511, ORIENT_HMIRROR, 1'b1));
        send_pixel(8'd255, 8'd255, 32'h0000_00AA);
        send_pixel(8'd0, 8'd0, 32'h0000_0001);

        // last word of the frame store is reachable
        apply_config(make_config(4095, 4095, 4096, 256, 256, ORIENT_NONE, 1'b1));
        send_pixel(8'd255, 8'd255, 32'h0000_0001);
        send_pixel(8'd0, 8'd0, 32'h0000_0002);

        // an address past the end of the frame store is dropped
        apply_config(make_config(4095, 4095, 8191, 256, 256, ORIENT_NONE, 1'b1));
        send_pixel(8'd255, 8'd255, 32'h0000_0001);
        send_pixel(8'd0, 8'd0, 32'h0000_0002);

        apply_config(make_config(10, 10, 1024, 1, 0, ORIENT_NONE, 1'b0));
        send_pixel(8'd0, 8'd0, 32'h0000_0001);

        // column runs past a one-word line
        apply_config(make_config(4095, 3, 1, 1, 1, ORIENT_NONE, 1'b0));
        send_pixel(8'd0, 8'd0, 32'h5555_5555);
        send_pixel(8'd1, 8'd0, 32'h5555_5555);

        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            phase++;
            if (phase == 6)
            begin
                // hold the output off while the input streams without gaps
                apply_config(make_config(0, 0, 1024, 1, 256, ORIENT_NONE, 1'b0));
                tx_idle_on = 1'b0;
                hold_request = 1'b1;
                phase_len = 200;
            end
            else
            begin
                c = random_config();
                apply_config(c);
                tx_idle_on = ($urandom_range(0, 2) != 0);
                phase_len = int'($urandom_range(20, 120));
            end
            side = int'(board.regs.sprite_size);
            if (side > SPRITE_MAX)
                side = SPRITE_MAX;
            repeat (phase_len)
            begin
                if (side == 0 || $urandom_range(0, 6) == 0)
                begin
                    col = COL_W'($urandom_range(0, 255));
                    row = COL_W'($urandom_range(0, 255));
                end
                else
                begin
                    col = COL_W'($urandom_range(0, side - 1));
                    row = COL_W'($urandom_range(0, side - 1));
                end
                send_pixel(col, row, random_pixel());
                random_sent++;
            end
        end

        drain_block();
        if (board.errors == 0 && board.expected_writes.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
